// File: design/raw_waw_interval_histogram_assert.svh
// Assertion macros used by raw_waw_interval_histogram.sv; clock and reset are the module ports.
`ifndef RAW_WAW_INTERVAL_HISTOGRAM_ASSERT_SVH
`define RAW_WAW_INTERVAL_HISTOGRAM_ASSERT_SVH

// same-cycle implication
`define RWIH_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rwih assertion failed");

// next-cycle implication
`define RWIH_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rwih assertion failed");

`endif

// File: design/rwih_pkg.sv
package rwih_pkg;

   localparam int TS_W    = 48;
   localparam int TICKS_W = 32;
   localparam int OFS_W   = 16;
   localparam int CNT_W   = 9;
   localparam int BIN_W   = 12;
   localparam int HCNT_W  = 32;

   localparam logic [TICKS_W-1:0] TICKS_RESET = 32'd10000000;

   typedef enum logic [1:0] {
      STAT_DONE     = 2'd0,
      STAT_DROPPED  = 2'd1,
      STAT_PARTIAL  = 2'd2,
      STAT_BIN_READ = 2'd3
   } status_type;

endpackage

// File: design/raw_waw_interval_histogram.sv
// Bin read: the bin is read in ST_HRD, the result is registered in ST_FIN; a dropped access
// goes straight to ST_FIN. Access: each block in the table is read (ST_LOOP, ST_BRD); a
// block last written is binned (shared restoring divider, a bit per cycle) and counted
// (ST_HREQ, ST_HUPD), and one beyond the table is skipped. One request at a time; the next
// beat is taken in the cycle after the result is registered. Reset is synchronous; after it
// a clearing pass (ST_CLEAR) wipes block state and both histograms, req_ready stays low.
`include "raw_waw_interval_histogram_assert.svh"

module raw_waw_interval_histogram import rwih_pkg::*; #(
   parameter int NUM_BLOCKS         = 65536,
   parameter int HIST_BINS          = 4096,
   parameter int MAX_BLOCKS_PER_REQ = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic [TS_W-1:0]    req_timestamp,
   input  logic               req_is_write,
   input  logic [OFS_W-1:0]   req_block_offset,
   input  logic [CNT_W-1:0]   req_block_count,
   input  logic               req_hist_select,
   input  logic [BIN_W-1:0]   req_bin_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [HCNT_W-1:0]  rsp_bin_count,
   output logic [CNT_W-1:0]   rsp_raw_hits,
   output logic [CNT_W-1:0]   rsp_waw_hits,
   input  logic               csr_wr_en,
   input  logic [TICKS_W-1:0] csr_wr_data
);

   localparam int QW       = $clog2(HIST_BINS);
   localparam int HA_W     = QW + 1;
   localparam int HM_DEPTH = 2 ** HA_W;
   localparam int BA_W     = $clog2(NUM_BLOCKS);
   localparam int BX_W     = (BA_W > OFS_W + 1) ? BA_W : OFS_W + 1;
   localparam int SWEEP    = (NUM_BLOCKS > HM_DEPTH) ? NUM_BLOCKS : HM_DEPTH;
   localparam int CLR_W    = $clog2(SWEEP);

   typedef enum logic [1:0] {KIND_NONE, KIND_READ, KIND_WRITE} kind_type;

   typedef struct packed {
      kind_type        kind;
      logic [TS_W-1:0] stamp;
   } blk_entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_HRD, ST_LOOP, ST_BRD, ST_DIV, ST_HREQ, ST_HUPD, ST_FIN
   } state_type;

   state_type          state_ff;
   logic [CLR_W-1:0]   clr_ff;
   logic [TICKS_W-1:0] ticks_ff;
   logic               seen_ff;
   logic [TS_W-1:0]    last_ff;
   logic [TS_W-1:0]    now_ff;
   logic               wr_ff;
   logic [BX_W-1:0]    blk_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               partial_ff;
   logic               bin_ok_ff;
   logic [QW-1:0]      bin_ff;
   logic [CNT_W-1:0]   raw_ff;
   logic [CNT_W-1:0]   waw_ff;
   status_type         res_status_ff;
   logic [HCNT_W-1:0]  res_count_ff;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [HCNT_W-1:0]  rsp_bin_count_ff;
   logic [CNT_W-1:0]   rsp_raw_hits_ff;
   logic [CNT_W-1:0]   rsp_waw_hits_ff;

   blk_entry_type      blk_mem [NUM_BLOCKS];
   blk_entry_type      bm_q_ff;
   logic [HCNT_W-1:0]  hist_mem [HM_DEPTH];
   logic [HCNT_W-1:0]  hm_q_ff;

   logic               accept;
   logic               in_range;
   logic               at_end;
   logic               bm_re;
   logic               bm_we;
   logic [BA_W-1:0]    bm_waddr;
   blk_entry_type      bm_wdata;
   logic               hm_re;
   logic [HA_W-1:0]    hm_raddr;
   logic               hm_we;
   logic [HA_W-1:0]    hm_waddr;
   logic [HCNT_W-1:0]  hm_wdata;
   logic               clr_blk;
   logic               clr_hist;
   logic               div_start;
   logic               div_done;
   logic [QW-1:0]      div_q;
   logic [TICKS_W-1:0] divisor;
   logic               back_in_time;

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign in_range     = (32'(blk_ff) < 32'(NUM_BLOCKS));
   assign at_end       = (idx_ff == cnt_ff);
   assign clr_blk      = (32'(clr_ff) < 32'(NUM_BLOCKS));
   assign clr_hist     = (32'(clr_ff) < 32'(HM_DEPTH));
   assign divisor      = (ticks_ff == '0) ? TICKS_W'(1) : ticks_ff;
   assign back_in_time = (now_ff < bm_q_ff.stamp);
   assign div_start    = (state_ff == ST_BRD) && (bm_q_ff.kind == KIND_WRITE) && !back_in_time;

   always_comb begin
      bm_re    = (state_ff == ST_LOOP) && !at_end && in_range;
      bm_we    = 1'b0;
      bm_waddr = blk_ff[BA_W-1:0];
      bm_wdata = '{kind: (wr_ff ? KIND_WRITE : KIND_READ), stamp: now_ff};
      hm_re    = 1'b0;
      hm_raddr = {wr_ff, bin_ff};
      hm_we    = 1'b0;
      hm_waddr = {wr_ff, bin_ff};
      hm_wdata = (hm_q_ff == '1) ? hm_q_ff : hm_q_ff + 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            bm_we    = clr_blk;
            bm_waddr = clr_ff[BA_W-1:0];
            bm_wdata = '{kind: KIND_NONE, stamp: '0};
            hm_we    = clr_hist;
            hm_waddr = clr_ff[HA_W-1:0];
            hm_wdata = '0;
         end
         ST_IDLE: begin
            hm_re    = accept && req_type;
            hm_raddr = {req_hist_select, QW'(req_bin_index)};
         end
         ST_BRD:  bm_we = (bm_q_ff.kind != KIND_WRITE);
         ST_HREQ: hm_re = 1'b1;
         ST_HUPD: begin
            bm_we = 1'b1;
            hm_we = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (bm_we) begin
         blk_mem[bm_waddr] <= bm_wdata;
      end
      if (bm_re) begin
         bm_q_ff <= blk_mem[blk_ff[BA_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (hm_we) begin
         hist_mem[hm_waddr] <= hm_wdata;
      end
      if (hm_re) begin
         hm_q_ff <= hist_mem[hm_raddr];
      end
   end

   rwih_div #(
      .HIST_BINS (HIST_BINS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (now_ff - bm_q_ff.stamp),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         ticks_ff     <= TICKS_RESET;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            ticks_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CLR_W'(SWEEP - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  raw_ff       <= '0;
                  waw_ff       <= '0;
                  res_count_ff <= '0;
                  if (req_type) begin
                     bin_ok_ff <= (32'(req_bin_index) < 32'(HIST_BINS));
                     state_ff  <= ST_HRD;
                  end else if (seen_ff && (req_timestamp < last_ff)) begin
                     res_status_ff <= STAT_DROPPED;
                     state_ff      <= ST_FIN;
                  end else begin
                     seen_ff    <= 1'b1;
                     last_ff    <= req_timestamp;
                     now_ff     <= req_timestamp;
                     wr_ff      <= req_is_write;
                     blk_ff     <= BX_W'(req_block_offset);
                     idx_ff     <= '0;
                     cnt_ff     <= (32'(req_block_count) > 32'(MAX_BLOCKS_PER_REQ)) ?
                                   CNT_W'(MAX_BLOCKS_PER_REQ) : req_block_count;
                     partial_ff <= 1'b0;
                     state_ff   <= ST_LOOP;
                  end
               end
            end
            ST_HRD: begin
               res_count_ff  <= bin_ok_ff ? hm_q_ff : '0;
               res_status_ff <= STAT_BIN_READ;
               state_ff      <= ST_FIN;
            end
            ST_LOOP: begin
               if (at_end) begin
                  res_status_ff <= partial_ff ? STAT_PARTIAL : STAT_DONE;
                  state_ff      <= ST_FIN;
               end else if (!in_range) begin
                  // block past the table: skip it, flag the access
                  partial_ff <= 1'b1;
                  idx_ff     <= idx_ff + 1'b1;
                  blk_ff     <= blk_ff + 1'b1;
               end else begin
                  state_ff <= ST_BRD;
               end
            end
            ST_BRD: begin
               if (bm_q_ff.kind == KIND_WRITE) begin
                  if (back_in_time) begin
                     bin_ff   <= QW'(HIST_BINS - 1);
                     state_ff <= ST_HREQ;
                  end else begin
                     state_ff <= ST_DIV;
                  end
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  blk_ff   <= blk_ff + 1'b1;
                  state_ff <= ST_LOOP;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  bin_ff   <= div_q;
                  state_ff <= ST_HREQ;
               end
            end
            ST_HREQ: state_ff <= ST_HUPD;
            ST_HUPD: begin
               if (wr_ff) begin
                  waw_ff <= (waw_ff == '1) ? waw_ff : waw_ff + 1'b1;
               end else begin
                  raw_ff <= (raw_ff == '1) ? raw_ff : raw_ff + 1'b1;
               end
               idx_ff   <= idx_ff + 1'b1;
               blk_ff   <= blk_ff + 1'b1;
               state_ff <= ST_LOOP;
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_status_ff    <= res_status_ff;
                  rsp_bin_count_ff <= res_count_ff;
                  rsp_raw_hits_ff  <= raw_ff;
                  rsp_waw_hits_ff  <= waw_ff;
                  state_ff         <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_bin_count = rsp_bin_count_ff;
   assign rsp_raw_hits  = rsp_raw_hits_ff;
   assign rsp_waw_hits  = rsp_waw_hits_ff;

   `RWIH_ASSERT_IMP(a_div_start_on_write, div_start, bm_q_ff.kind == KIND_WRITE)
   `RWIH_ASSERT_IMP(a_div_done_in_div, div_done, state_ff == ST_DIV)
   `RWIH_ASSERT_IMP(a_idx_bound, state_ff == ST_LOOP, idx_ff <= cnt_ff)
   `RWIH_ASSERT_IMP(a_one_kind_hits, rsp_valid_ff, rsp_raw_hits_ff == '0 || rsp_waw_hits_ff == '0)
   `RWIH_ASSERT_NXT(a_hupd_after_hreq, state_ff == ST_HREQ, state_ff == ST_HUPD)

endmodule

// File: design/rwih_div.sv
module rwih_div import rwih_pkg::*; #(
   parameter int HIST_BINS = 4096,
   localparam int QW = $clog2(HIST_BINS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [TS_W-1:0]    dividend,
   input  logic [TICKS_W-1:0] divisor,
   output logic               done,
   output logic [QW-1:0]      quotient
);

   localparam int LW = TICKS_W + QW;
   localparam int CW = (TS_W > LW) ? TS_W : LW;
   localparam int SW = $clog2(QW);

   typedef enum logic [1:0] {D_IDLE, D_MUL, D_CHK, D_STEP} state_type;

   state_type          state_ff;
   logic [CW-1:0]      rem_ff;
   logic [TICKS_W-1:0] dvs_ff;
   logic [LW-1:0]      lim_ff;
   logic [CW-1:0]      dsh_ff;
   logic [SW-1:0]      step_ff;
   logic [QW-1:0]      q_ff;
   logic               done_ff;
   logic               fits;

   // one restoring step: current divisor multiple fits into the remainder
   assign fits = (rem_ff >= dsh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         case (state_ff)
            D_IDLE: begin
               done_ff <= 1'b0;
               if (start) begin
                  rem_ff   <= CW'(dividend);
                  dvs_ff   <= divisor;
                  state_ff <= D_MUL;
               end
            end
            D_MUL: begin
               // quotient saturates once elapsed reaches divisor * bins
               lim_ff   <= LW'(dvs_ff) * LW'(HIST_BINS);
               dsh_ff   <= CW'(dvs_ff) << (QW - 1);
               step_ff  <= SW'(QW - 1);
               q_ff     <= '0;
               state_ff <= D_CHK;
            end
            D_CHK: begin
               if (rem_ff >= CW'(lim_ff)) begin
                  q_ff     <= QW'(HIST_BINS - 1);
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end else begin
                  state_ff <= D_STEP;
               end
            end
            D_STEP: begin
               if (fits) begin
                  rem_ff <= rem_ff - dsh_ff;
               end
               q_ff   <= {q_ff[QW-2:0], fits};
               dsh_ff <= dsh_ff >> 1;
               if (step_ff == '0) begin
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end else begin
                  step_ff <= step_ff - 1'b1;
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import rwih_pkg::*;

   localparam int NUM_BLOCKS         = 65536;
   localparam int HIST_BINS          = 4096;
   localparam int MAX_BLOCKS_PER_REQ = 256;
   localparam logic [CNT_W-1:0]  HIT_CAP   = 9'd511;
   localparam logic [HCNT_W-1:0] COUNT_CAP = 32'hFFFF_FFFF;
   localparam logic [TS_W-1:0]   STAMP_MAX = {TS_W{1'b1}};

   localparam logic REQ_ACCESS   = 1'b0;
   localparam logic REQ_BIN_READ = 1'b1;
   localparam logic HIST_RAW     = 1'b0;
   localparam logic HIST_WAW     = 1'b1;
   localparam logic ACC_READ     = 1'b0;
   localparam logic ACC_WRITE    = 1'b1;

   typedef enum logic [1:0] {
      BLK_UNTOUCHED = 2'd0,
      BLK_READ      = 2'd1,
      BLK_WRITTEN   = 2'd2
   } blk_kind_type;

   typedef struct {
      logic             kind;
      logic [TS_W-1:0]  stamp;
      logic             wr;
      logic [OFS_W-1:0] ofs;
      logic [CNT_W-1:0] cnt;
      logic             sel;
      logic [BIN_W-1:0] bin;
   } interval_req_type;

   typedef struct {
      status_type        status;
      logic [HCNT_W-1:0] count;
      logic [CNT_W-1:0]  raw;
      logic [CNT_W-1:0]  waw;
   } interval_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = REQ_ACCESS;
   logic [TS_W-1:0] req_timestamp = '0;
   logic req_is_write = ACC_READ;
   logic [OFS_W-1:0] req_block_offset = '0;
   logic [CNT_W-1:0] req_block_count = '0;
   logic req_hist_select = HIST_RAW;
   logic [BIN_W-1:0] req_bin_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [HCNT_W-1:0] rsp_bin_count;
   logic [CNT_W-1:0] rsp_raw_hits;
   logic [CNT_W-1:0] rsp_waw_hits;
   logic csr_wr_en = 1'b0;
   logic [TICKS_W-1:0] csr_wr_data = '0;

   // profiler image kept by the testbench
   blk_kind_type      last_kind [NUM_BLOCKS];
   logic [TS_W-1:0]   last_stamp [NUM_BLOCKS];
   logic [HCNT_W-1:0] raw_bins [HIST_BINS];
   logic [HCNT_W-1:0] waw_bins [HIST_BINS];
   logic [TS_W-1:0]   newest_stamp;
   logic              stamp_seen;
   logic [TICKS_W-1:0] bin_width;

   interval_rsp_type pending_rsp [$];
   int unsigned fail_count = 0;
   bit sender_idles = 1'b1;
   bit sink_idles = 1'b1;
   bit hold_sink = 1'b0;
   int unsigned sink_gap = 0;

   raw_waw_interval_histogram #(
      .NUM_BLOCKS(NUM_BLOCKS),
      .HIST_BINS(HIST_BINS),
      .MAX_BLOCKS_PER_REQ(MAX_BLOCKS_PER_REQ)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_timestamp(req_timestamp),
      .req_is_write(req_is_write),
      .req_block_offset(req_block_offset),
      .req_block_count(req_block_count),
      .req_hist_select(req_hist_select),
      .req_bin_index(req_bin_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_bin_count(rsp_bin_count),
      .rsp_raw_hits(rsp_raw_hits),
      .rsp_waw_hits(rsp_waw_hits),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // Walks the covered blocks, bins the time since each block's last write.
   function automatic interval_rsp_type tally_request(input interval_req_type r);
      interval_rsp_type res;
      longint unsigned width;
      longint unsigned gap;
      longint unsigned blk;
      int unsigned span;
      logic [BIN_W-1:0] bin;
      res = '{status: STAT_DONE, count: '0, raw: '0, waw: '0};
      if (r.kind == REQ_BIN_READ) begin
         res.status = STAT_BIN_READ;
         if (r.bin < HIST_BINS)
            res.count = (r.sel == HIST_WAW) ? waw_bins[r.bin] : raw_bins[r.bin];
         return res;
      end
      if (stamp_seen && r.stamp < newest_stamp) begin
         res.status = STAT_DROPPED;
         return res;
      end
      stamp_seen = 1'b1;
      newest_stamp = r.stamp;
      span = (r.cnt > MAX_BLOCKS_PER_REQ) ? MAX_BLOCKS_PER_REQ : r.cnt;
      width = (bin_width == 0) ? 1 : bin_width;
      for (int i = 0; i < span; i++) begin
         blk = r.ofs + i;
         if (blk >= NUM_BLOCKS) begin
            res.status = STAT_PARTIAL;
            continue;
         end
         if (last_kind[blk] == BLK_WRITTEN) begin
            if (r.stamp < last_stamp[blk]) begin
               bin = BIN_W'(HIST_BINS - 1);
            end else begin
               gap = (r.stamp - last_stamp[blk]) / width;
               bin = (gap >= HIST_BINS) ? BIN_W'(HIST_BINS - 1) : gap[BIN_W-1:0];
            end
            if (r.wr == ACC_WRITE) begin
               if (waw_bins[bin] != COUNT_CAP) waw_bins[bin] = waw_bins[bin] + 1'b1;
               if (res.waw != HIT_CAP) res.waw = res.waw + 1'b1;
            end else begin
               if (raw_bins[bin] != COUNT_CAP) raw_bins[bin] = raw_bins[bin] + 1'b1;
               if (res.raw != HIT_CAP) res.raw = res.raw + 1'b1;
            end
         end
         last_kind[blk] = (r.wr == ACC_WRITE) ? BLK_WRITTEN : BLK_READ;
         last_stamp[blk] = r.stamp;
      end
      return res;
   endfunction

   function automatic interval_req_type access_req(input logic [TS_W-1:0] t, input logic w,
                                                   input logic [OFS_W-1:0] o,
                                                   input logic [CNT_W-1:0] n);
      interval_req_type r;
      r = '{kind: REQ_ACCESS, stamp: t, wr: w, ofs: o, cnt: n, sel: HIST_RAW, bin: '0};
      return r;
   endfunction

   function automatic interval_req_type bin_req(input logic s, input logic [BIN_W-1:0] b);
      interval_req_type r;
      r = '{kind: REQ_BIN_READ, stamp: '0, wr: ACC_READ, ofs: '0, cnt: '0, sel: s, bin: b};
      return r;
   endfunction

   // Mostly in-order accesses on a hot window, plus bin reads and late beats.
   function automatic interval_req_type random_request();
      interval_req_type r;
      int unsigned pick;
      longint unsigned width;
      longint unsigned step;
      longint unsigned stamp;
      r.kind = REQ_ACCESS;
      r.stamp = {16'($urandom), $urandom};
      r.wr = 1'($urandom);
      r.ofs = 16'($urandom);
      r.cnt = 9'($urandom);
      r.sel = 1'($urandom);
      r.bin = 12'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         r.kind = REQ_BIN_READ;
         case ($urandom_range(0, 3))
            0: r.bin = '0;
            1: r.bin = BIN_W'(HIST_BINS - 1);
            2: r.bin = 12'($urandom);
            default: r.bin = 12'($urandom_range(0, 15));
         endcase
         return r;
      end
      if (pick < 28 && stamp_seen && newest_stamp != 0) begin
         stamp = {$urandom, $urandom};
         r.stamp = (pick < 22) ? newest_stamp - 1'b1 : TS_W'(stamp % newest_stamp);
         return r;
      end
      width = (bin_width == 0) ? 1 : bin_width;
      case ($urandom_range(0, 7))
         0, 1: step = 0;
         2, 3: step = longint'($urandom_range(0, 2)) * width + longint'($urandom) % width;
         4, 5, 6: step = longint'($urandom_range(0, 40)) * width;
         default: step = longint'($urandom_range(4000, 4200)) * width;
      endcase
      stamp = newest_stamp + step;
      r.stamp = (stamp > STAMP_MAX) ? STAMP_MAX : stamp[TS_W-1:0];
      case ($urandom_range(0, 19))
         0, 1, 2: r.ofs = 16'($urandom_range(65280, 65535));
         3, 4, 5: r.ofs = 16'($urandom);
         default: r.ofs = 16'($urandom_range(0, 1023));
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 60)      r.cnt = 9'($urandom_range(1, 8));
      else if (pick < 85) r.cnt = 9'($urandom_range(0, 32));
      else if (pick < 95) r.cnt = 9'($urandom_range(33, 256));
      else                r.cnt = 9'($urandom_range(257, 511));
      return r;
   endfunction

   task automatic send_req(input interval_req_type r);
      @(negedge clock);
      if (sender_idles && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_type <= r.kind;
      req_timestamp <= r.stamp;
      req_is_write <= r.wr;
      req_block_offset <= r.ofs;
      req_block_count <= r.cnt;
      req_hist_select <= r.sel;
      req_bin_index <= r.bin;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(tally_request(r));
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_bin_width(input logic [TICKS_W-1:0] w);
      wait_drain();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= w;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      bin_width = w;
   endtask

   task automatic apply_reset();
      foreach (last_kind[i]) begin
         last_kind[i] = BLK_UNTOUCHED;
         last_stamp[i] = '0;
      end
      foreach (raw_bins[i]) begin
         raw_bins[i] = '0;
         waw_bins[i] = '0;
      end
      newest_stamp = '0;
      stamp_seen = 1'b0;
      bin_width = TICKS_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   endtask

   task automatic test_directed();
      send_req(bin_req(HIST_RAW, 12'd0));
      send_req(bin_req(HIST_WAW, 12'd4095));
      // first access takes any time; the one after it is late and dropped
      send_req(access_req(48'd5000, ACC_WRITE, 16'd10, 9'd4));
      send_req(access_req(48'd4999, ACC_READ, 16'd10, 9'd4));
      send_req(access_req(48'd5000, ACC_READ, 16'd10, 9'd2));
      send_req(access_req(48'd35_005_000, ACC_WRITE, 16'd11, 9'd3));
      send_req(access_req(48'd35_005_000, ACC_WRITE, 16'd500, 9'd0));
      // oversized count clamps to the per-request max
      send_req(access_req(48'd35_005_001, ACC_WRITE, 16'd0, 9'd511));
      // long interval lands in the last bin
      send_req(access_req(48'd50_000_000_000, ACC_READ, 16'd0, 9'd256));
      send_req(access_req(48'd50_000_000_000, ACC_READ, 16'd65535, 9'd256));
      send_req(access_req(48'd50_000_000_000, ACC_WRITE, 16'd65408, 9'd300));
      send_req(access_req(48'd50_000_000_001, ACC_WRITE, 16'd65535, 9'd1));
      send_req(access_req(48'd50_000_000_002, ACC_WRITE, 16'd65535, 9'd1));
      send_req(bin_req(HIST_RAW, 12'd0));
      send_req(bin_req(HIST_RAW, 12'd4095));
      send_req(bin_req(HIST_WAW, 12'd3));
      send_req(bin_req(HIST_WAW, 12'd0));
      send_req(bin_req(HIST_WAW, 12'd4095));
      send_req(bin_req(HIST_RAW, 12'd1));
   endtask

   task automatic test_bin_widths();
      logic [TICKS_W-1:0] widths [5];
      widths = '{32'd1, 32'd0, 32'd1000, 32'($urandom_range(2, 1_000_000)), 32'hFFFF_FFFF};
      for (int p = 0; p < 5; p++) begin
         set_bin_width(widths[p]);
         sender_idles = (p != 2);
         sink_idles = (p != 3);
         repeat (110) send_req(random_request());
      end
      sender_idles = 1'b1;
      sink_idles = 1'b1;
   endtask

   task automatic test_backpressure();
      sender_idles = 1'b0;
      fork
         begin
            hold_sink = 1'b1;
            repeat (400) @(posedge clock);
            hold_sink = 1'b0;
         end
         repeat (20) send_req(random_request());
      join
      // sender stops until every result is back
      wait_drain();
      sender_idles = 1'b1;
   endtask

   task automatic test_time_ceiling();
      set_bin_width(32'($urandom_range(2, 2_000_000)));
      sender_idles = 1'b0;
      sink_idles = 1'b0;
      send_req(access_req(STAMP_MAX - 48'd5_000_000, ACC_WRITE, 16'd0, 9'd64));
      repeat (140) send_req(random_request());
      send_req(access_req(STAMP_MAX, ACC_READ, 16'd0, 9'd64));
      send_req(access_req(STAMP_MAX, ACC_WRITE, 16'd32, 9'd64));
      send_req(bin_req(HIST_RAW, 12'd4095));
      send_req(bin_req(HIST_WAW, 12'd0));
   endtask

   // response side: random stall bursts, or held off entirely on request
   always @(negedge clock) begin
      if (hold_sink) begin
         rsp_ready <= 1'b0;
      end else if (sink_gap != 0) begin
         sink_gap <= sink_gap - 1;
         rsp_ready <= 1'b0;
      end else if (sink_idles && $urandom_range(0, 4) == 0) begin
         sink_gap <= $urandom_range(0, 16);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic void check_field(input string what, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      interval_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: result beat with nothing expected, status %0h", $time, rsp_status);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("bin_count", want.count, rsp_bin_count);
            check_field("raw_hits", want.raw, rsp_raw_hits);
            check_field("waw_hits", want.waw, rsp_waw_hits);
         end
      end
   end

   initial begin
      apply_reset();
      test_directed();
      test_bin_widths();
      test_backpressure();
      test_time_ceiling();
      wait_drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      #250_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule
